FILE: rtl/csim_pkg.sv
// Shared constants and control/status structs for the cosine similarity block.
// No dependencies; used by csim_dp, csim_ctrl and cosine_similarity_stream_top.
package csim_pkg;

  localparam int ELEM_W     = 16;
  localparam int FIELD_W    = 16;
  localparam int ACC_W      = 48;
  localparam int ROOT_W     = ACC_W / 2;
  localparam int SCORE_W    = 16;
  localparam int FRAC_OUT   = 14;
  localparam int QUO_W      = FRAC_OUT + 1;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = QUO_W;
  localparam int CNT_W      = $clog2(SQRT_STEPS);
  localparam int PROD_W     = 2 * ELEM_W;
  localparam int NUM_W      = ACC_W + FRAC_OUT;

  localparam logic [QUO_W-1:0] SCORE_ONE = QUO_W'(1 << FRAC_OUT);

  typedef struct packed {
    logic take;
    logic sqrt_step;
    logic mul;
    logic div_init;
    logic div_step;
    logic load_out;
  } csim_cmd_t;

  typedef struct packed {
    logic fin_last;
    logic out_free;
  } csim_sts_t;

endpackage

FILE: rtl/csim_dp.sv
// Datapath: product stage, saturating sums, two root units, divider, result register.
// Depends on csim_pkg; driven by csim_ctrl commands.
module csim_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  csim_pkg::csim_cmd_t                   cmd,
  output csim_pkg::csim_sts_t                   sts,
  input  logic signed [csim_pkg::FIELD_W-1:0]   in_elem_a,
  input  logic signed [csim_pkg::FIELD_W-1:0]   in_elem_b,
  input  logic                                  in_last,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [csim_pkg::SCORE_W-1:0]   out_score,
  output logic                                  out_zero_norm
);
  import csim_pkg::*;

  function automatic logic [2*ACC_W-1:0] root_step(input logic [ACC_W-1:0] x,
                                                   input logic [ACC_W-1:0] r,
                                                   input logic [ACC_W-1:0] b);
    logic [ACC_W:0] trial;
    trial = {1'b0, r} + {1'b0, b};
    if ({1'b0, x} >= trial) begin
      root_step = {x - trial[ACC_W-1:0], (r >> 1) + b};
    end else begin
      root_step = {x, r >> 1};
    end
  endfunction

  logic signed [ELEM_W-1:0] ea, eb;
  logic signed [PROD_W-1:0] prod_ab, prod_aa, prod_bb;

  logic                     p_valid_r, p_last_r;
  logic signed [PROD_W-1:0] p_ab_r;
  logic [PROD_W-2:0]        p_aa_r, p_bb_r;

  logic signed [ACC_W-1:0]  dot_acc_r;
  logic [ACC_W-1:0]         norm_a_acc_r, norm_b_acc_r;
  logic signed [ACC_W:0]    dot_sum;
  logic [ACC_W:0]           na_sum, nb_sum;
  logic signed [ACC_W-1:0]  dot_sat;
  logic [ACC_W-1:0]         na_sat, nb_sat;
  logic                     fin;

  logic [ACC_W-1:0]         xa_r, xb_r, ra_r, rb_r, bit_r, mag_r;
  logic [2*ACC_W-1:0]       step_a, step_b;
  logic                     neg_r, zn_r, over_r;
  logic [ACC_W-1:0]         den_r;
  logic [NUM_W-1:0]         rem_r, d_r;
  logic [QUO_W-1:0]         q_r, q_clamp;
  logic [SCORE_W-1:0]       score_nxt;

  logic                     out_valid_r, out_zn_r;
  logic [SCORE_W-1:0]       out_score_r;

  assign ea      = in_elem_a[ELEM_W-1:0];
  assign eb      = in_elem_b[ELEM_W-1:0];
  assign prod_ab = ea * eb;
  assign prod_aa = ea * ea;
  assign prod_bb = eb * eb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= cmd.take;
    end
    if (cmd.take) begin
      p_last_r <= in_last;
      p_ab_r   <= prod_ab;
      p_aa_r   <= prod_aa[PROD_W-2:0];
      p_bb_r   <= prod_bb[PROD_W-2:0];
    end
  end

  assign dot_sum = {dot_acc_r[ACC_W-1], dot_acc_r}
                 + {{(ACC_W+1-PROD_W){p_ab_r[PROD_W-1]}}, p_ab_r};
  assign na_sum  = {1'b0, norm_a_acc_r} + {{(ACC_W+2-PROD_W){1'b0}}, p_aa_r};
  assign nb_sum  = {1'b0, norm_b_acc_r} + {{(ACC_W+2-PROD_W){1'b0}}, p_bb_r};

  always_comb begin
    if (dot_sum[ACC_W] != dot_sum[ACC_W-1]) begin
      dot_sat = dot_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      dot_sat = dot_sum[ACC_W-1:0];
    end
  end

  assign na_sat = na_sum[ACC_W] ? {ACC_W{1'b1}} : na_sum[ACC_W-1:0];
  assign nb_sat = nb_sum[ACC_W] ? {ACC_W{1'b1}} : nb_sum[ACC_W-1:0];
  assign fin    = p_valid_r & p_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_acc_r    <= '0;
      norm_a_acc_r <= '0;
      norm_b_acc_r <= '0;
    end else if (p_valid_r) begin
      if (p_last_r) begin
        dot_acc_r    <= '0;
        norm_a_acc_r <= '0;
        norm_b_acc_r <= '0;
      end else begin
        dot_acc_r    <= dot_sat;
        norm_a_acc_r <= na_sat;
        norm_b_acc_r <= nb_sat;
      end
    end
  end

  assign step_a = root_step(xa_r, ra_r, bit_r);
  assign step_b = root_step(xb_r, rb_r, bit_r);

  always_ff @(posedge clk) begin
    if (fin) begin
      xa_r  <= na_sat;
      xb_r  <= nb_sat;
      ra_r  <= '0;
      rb_r  <= '0;
      bit_r <= ACC_W'(1) << (ACC_W - 2);
      neg_r <= dot_sat[ACC_W-1];
      mag_r <= dot_sat[ACC_W-1] ? (~dot_sat + ACC_W'(1)) : dot_sat;
      zn_r  <= (na_sat == '0) | (nb_sat == '0);
    end else if (cmd.sqrt_step) begin
      {xa_r, ra_r} <= step_a;
      {xb_r, rb_r} <= step_b;
      bit_r        <= bit_r >> 2;
    end
    if (cmd.mul) begin
      den_r <= ra_r[ROOT_W-1:0] * rb_r[ROOT_W-1:0];
    end
    if (cmd.div_init) begin
      d_r    <= {den_r, {FRAC_OUT{1'b0}}};
      rem_r  <= {mag_r, {FRAC_OUT{1'b0}}};
      over_r <= {1'b0, mag_r} >= {den_r, 1'b0};
      q_r    <= '0;
    end else if (cmd.div_step) begin
      if (rem_r >= d_r) begin
        rem_r <= rem_r - d_r;
        q_r   <= {q_r[QUO_W-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[QUO_W-2:0], 1'b0};
      end
      d_r <= d_r >> 1;
    end
  end

  always_comb begin
    q_clamp = (over_r || (q_r > SCORE_ONE)) ? SCORE_ONE : q_r;
    if (zn_r) begin
      score_nxt = '0;
    end else if (neg_r) begin
      score_nxt = SCORE_W'(0) - {{(SCORE_W-QUO_W){1'b0}}, q_clamp};
    end else begin
      score_nxt = {{(SCORE_W-QUO_W){1'b0}}, q_clamp};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.load_out) begin
      out_score_r <= score_nxt;
      out_zn_r    <= zn_r;
    end
  end

  assign sts.fin_last  = fin;
  assign sts.out_free  = ~out_valid_r | ~out_stall;
  assign out_valid     = out_valid_r;
  assign out_score     = out_score_r;
  assign out_zero_norm = out_zn_r;

endmodule

FILE: rtl/csim_ctrl.sv
// Controller: input stall, root/multiply/divide sequencing, result hand-off.
// Depends on csim_pkg; commands csim_dp.
module csim_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_stall,
  input  csim_pkg::csim_sts_t sts,
  output csim_pkg::csim_cmd_t cmd
);
  import csim_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQRT,
    S_MUL,
    S_INIT,
    S_DIV,
    S_DONE
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;

  assign in_stall = in_last & ((state_r != S_IDLE) | sts.fin_last);

  always_comb begin
    cmd           = '0;
    cmd.take      = in_valid & ~in_stall;
    cmd.sqrt_step = (state_r == S_SQRT);
    cmd.mul       = (state_r == S_MUL);
    cmd.div_init  = (state_r == S_INIT);
    cmd.div_step  = (state_r == S_DIV);
    cmd.load_out  = (state_r == S_DONE) & sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (sts.fin_last) begin
            state_r <= S_SQRT;
            cnt_r   <= CNT_W'(SQRT_STEPS - 1);
          end
        end
        S_SQRT: begin
          if (cnt_r == '0) begin
            state_r <= S_MUL;
          end else begin
            cnt_r <= cnt_r - CNT_W'(1);
          end
        end
        S_MUL: begin
          state_r <= S_INIT;
        end
        S_INIT: begin
          state_r <= S_DIV;
          cnt_r   <= CNT_W'(DIV_STEPS - 1);
        end
        S_DIV: begin
          if (cnt_r == '0) begin
            state_r <= S_DONE;
          end else begin
            cnt_r <= cnt_r - CNT_W'(1);
          end
        end
        S_DONE: begin
          if (sts.out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_fin_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sts.fin_last |-> state_r == S_IDLE)
    else $error("vector end reached stage two while finisher busy");

  a_stall_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_last)
    else $error("non-final transaction stalled");

  a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && sts.out_free |=> state_r == S_IDLE)
    else $error("finisher did not release after result load");

  a_mul_after_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> $past(state_r) == S_SQRT)
    else $error("multiply entered without root sequence");

endmodule

FILE: rtl/cosine_similarity_stream_top.sv
// Channel  | ports                                        | direction
// in       | in_valid, in_stall, in_elem_a, in_elem_b, in_last | element pairs in
// out      | out_valid, out_stall, out_score, out_zero_norm    | one score per vector
// Element pairs are taken one per cycle while in_stall is low; products are
// registered, then summed. A score passes the product stage, 24 root steps,
// one 24x24 multiply, divider setup, 15 divide steps and the result load.
// A final pair stalls while the previous vector is scored or its score is stalled.
// Reset (rst_n low, synchronous) clears the sums, the sequencer and out_valid.
// Top level; depends on csim_pkg, csim_dp and csim_ctrl.
module cosine_similarity_stream_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [csim_pkg::FIELD_W-1:0]   in_elem_a,
  input  logic signed [csim_pkg::FIELD_W-1:0]   in_elem_b,
  input  logic                                  in_last,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [csim_pkg::SCORE_W-1:0]   out_score,
  output logic                                  out_zero_norm
);
  import csim_pkg::*;

  csim_cmd_t cmd;
  csim_sts_t sts;

  csim_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  csim_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_elem_a     (in_elem_a),
    .in_elem_b     (in_elem_b),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_score     (out_score),
    .out_zero_norm (out_zero_norm)
  );

endmodule

FILE: tb/tb_cosine_similarity_stream_top.sv
// Self-checking testbench for cosine_similarity_stream_top: streams element pairs
// and predicts each vector's Q2.14 score and zero-norm flag from its own sums.
// Depends on csim_pkg and cosine_similarity_stream_top.
`timescale 1ns / 100ps

module tb_cosine_similarity_stream_top;

  localparam int FW = csim_pkg::FIELD_W;
  localparam int SW = csim_pkg::SCORE_W;
  localparam longint DOT_MAX = (longint'(1) << (csim_pkg::ACC_W - 1)) - 1;
  localparam longint DOT_MIN = -DOT_MAX - 1;
  localparam logic [63:0] NORM_MAX = (64'd1 << csim_pkg::ACC_W) - 1;
  localparam int RAND_ITEMS = 1400;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 100;

  typedef enum int unsigned {
    MIX_FULL, MIX_EXTREME, MIX_SMALL, MIX_ZERO_A, MIX_ZERO_B, MIX_ALIGNED, MIX_OPPOSED
  } mix_t;

  typedef struct {
    logic signed [FW-1:0] a;
    logic signed [FW-1:0] b;
    logic                 last;
    int unsigned          gap_max;
  } pair_t;

  typedef struct packed {
    logic signed [SW-1:0] score;
    logic                 zero_norm;
  } score_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [FW-1:0] in_elem_a = '0;
  logic signed [FW-1:0] in_elem_b = '0;
  logic                 in_last = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [SW-1:0] out_score;
  logic                 out_zero_norm;

  pair_t       pend_q[$];
  score_t      score_q[$];
  pair_t       cur;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  int unsigned rx_max = 12;
  int unsigned sent_cnt = 0;
  int unsigned taken_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned idle_cycles = 0;

  longint      dot_sum = 0;
  logic [63:0] sq_a_sum = '0;
  logic [63:0] sq_b_sum = '0;

  cosine_similarity_stream_top uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_elem_a    (in_elem_a),
    .in_elem_b    (in_elem_b),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_score    (out_score),
    .out_zero_norm(out_zero_norm)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] floor_root(input logic [63:0] x);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int i = csim_pkg::ROOT_W - 1; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  function automatic void accumulate_pair(input pair_t p);
    longint      prod;
    logic [63:0] mag;
    logic [63:0] quot;
    score_t      r;
    prod = longint'(p.a) * longint'(p.b);
    dot_sum = dot_sum + prod;
    if (dot_sum > DOT_MAX) dot_sum = DOT_MAX;
    else if (dot_sum < DOT_MIN) dot_sum = DOT_MIN;
    sq_a_sum = sq_a_sum + 64'(longint'(p.a) * longint'(p.a));
    if (sq_a_sum > NORM_MAX) sq_a_sum = NORM_MAX;
    sq_b_sum = sq_b_sum + 64'(longint'(p.b) * longint'(p.b));
    if (sq_b_sum > NORM_MAX) sq_b_sum = NORM_MAX;
    if (!p.last) return;
    r.score = '0;
    r.zero_norm = 1'b0;
    if (sq_a_sum == 0 || sq_b_sum == 0) begin
      r.zero_norm = 1'b1;
    end else begin
      mag = (dot_sum < 0) ? 64'(-dot_sum) : 64'(dot_sum);
      quot = (mag << csim_pkg::FRAC_OUT) / (floor_root(sq_a_sum) * floor_root(sq_b_sum));
      if (quot > 64'(csim_pkg::SCORE_ONE)) quot = 64'(csim_pkg::SCORE_ONE);
      r.score = (dot_sum < 0) ? -quot[SW-1:0] : quot[SW-1:0];
    end
    score_q.insert(score_q.size(), r);
    dot_sum = 0;
    sq_a_sum = '0;
    sq_b_sum = '0;
  endfunction

  function automatic logic signed [FW-1:0] pick_elem(input mix_t mix);
    logic signed [FW-1:0] v;
    case (mix)
      MIX_EXTREME: begin
        case ($urandom_range(0, 4))
          0: v = {1'b1, {(FW-1){1'b0}}};
          1: v = {1'b0, {(FW-1){1'b1}}};
          2: v = '0;
          3: v = '1;
          default: v = FW'(1);
        endcase
      end
      MIX_SMALL: v = FW'($urandom_range(0, 16)) - FW'(8);
      default: v = FW'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_pair(input logic signed [FW-1:0] a, input logic signed [FW-1:0] b,
                           input logic last, input int unsigned gmax);
    pair_t p;
    while (pend_q.size() >= 16) @(posedge clk);
    p.a = a;
    p.b = b;
    p.last = last;
    p.gap_max = gmax;
    pend_q.insert(pend_q.size(), p);
    sent_cnt++;
  endtask

  // driver: hold the payload while stalled, idle a drawn number of cycles after each transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_elem_a <= '0;
      in_elem_b <= '0;
      in_last <= 1'b0;
      gap_left = 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        accumulate_pair(cur);
        taken_cnt++;
      end
      if (gap_left == 0 && pend_q.size() != 0) begin
        cur = pend_q.pop_front();
        in_valid <= 1'b1;
        in_elem_a <= cur.a;
        in_elem_b <= cur.b;
        in_last <= cur.last;
        gap_left = $urandom_range(0, cur.gap_max);
      end else begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
        in_elem_a <= FW'($urandom);
        in_elem_b <= FW'($urandom);
        in_last <= 1'(($urandom));
      end
    end
  end

  // monitor: check each result transaction against the oldest predicted score
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (score_q.size() == 0) begin
          $display("%0t: unexpected result score=%0d zero_norm=%0b",
                   $time, out_score, out_zero_norm);
          mismatch_cnt++;
        end else begin
          if (score_q[0].score !== out_score) begin
            $display("%0t: score mismatch expected=%0d actual=%0d",
                     $time, score_q[0].score, out_score);
            mismatch_cnt++;
          end
          if (score_q[0].zero_norm !== out_zero_norm) begin
            $display("%0t: zero_norm mismatch expected=%0b actual=%0b",
                     $time, score_q[0].zero_norm, out_zero_norm);
            mismatch_cnt++;
          end
          void'(score_q.pop_front());
        end
        hold_left = $urandom_range(0, rx_max);
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_stall <= (hold_left != 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int unsigned rand_sent;
    int unsigned len;
    int unsigned gmax;
    mix_t mix;
    logic signed [FW-1:0] ea;
    logic signed [FW-1:0] eb;
    rand_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // single-pair vectors at the extremes
    send_pair(16'sh7FFF, 16'sh7FFF, 1'b1, 12);
    send_pair(16'sh8000, 16'sh8000, 1'b1, 12);
    send_pair(16'sh8000, 16'sh7FFF, 1'b1, 12);
    // zero norms
    send_pair(16'sd0, 16'sd0, 1'b1, 12);
    send_pair(16'sd12345, 16'sd0, 1'b1, 12);
    send_pair(16'sd0, -16'sd1, 1'b1, 12);
    send_pair(16'sd0, 16'sd100, 1'b0, 12);
    send_pair(16'sd0, -16'sd200, 1'b0, 12);
    send_pair(16'sd0, 16'sd7, 1'b1, 12);
    // orthogonal vectors
    send_pair(16'sd1, 16'sd0, 1'b0, 12);
    send_pair(16'sd0, 16'sd1, 1'b1, 12);
    // root truncation pushes the quotient past one: clamp both ways
    send_pair(16'sd3, 16'sd3, 1'b0, 12);
    send_pair(16'sd3, 16'sd3, 1'b1, 12);
    send_pair(16'sd3, -16'sd3, 1'b0, 0);
    send_pair(16'sd3, -16'sd3, 1'b1, 0);
    send_pair(-16'sd1, 16'sd1, 1'b0, 0);
    send_pair(16'sd21845, -16'sd10923, 1'b0, 0);
    send_pair(-16'sd12000, 16'sd30000, 1'b1, 12);
    send_pair(16'sh7FFF, 16'sh8000, 1'b0, 12);
    send_pair(16'sh8000, 16'sh7FFF, 1'b1, 12);

    while (rand_sent < RAND_ITEMS) begin
      if ($urandom_range(0, 9) == 0) rx_max = $urandom_range(0, 1) ? 12 : 0;
      mix = mix_t'($urandom_range(0, 6));
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
      gmax = ($urandom_range(0, 3) == 0) ? 0 : 12;
      for (int k = 0; k < len; k++) begin
        ea = pick_elem(mix);
        eb = pick_elem(mix);
        case (mix)
          MIX_ZERO_A: ea = '0;
          MIX_ZERO_B: eb = '0;
          MIX_ALIGNED: eb = ea;
          MIX_OPPOSED: eb = -ea;
          default: ;
        endcase
        send_pair(ea, eb, k == len - 1, gmax);
      end
      rand_sent += len;
    end

    while (taken_cnt != sent_cnt || score_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/csim_pkg.sv
rtl/csim_dp.sv
rtl/csim_ctrl.sv
rtl/cosine_similarity_stream_top.sv
tb/tb_cosine_similarity_stream_top.sv
